### design/trto_pkg.sv
// ----------------------------------------------------------------------------
// trto_pkg
// shared types, codes and constants of the tcp retransmission timeout estimator
// ----------------------------------------------------------------------------
package trto_pkg;

    // time base and sequence widths
    localparam int TIME_BITS     = 48;
    localparam int SEQ_BITS      = 32;
    localparam int RTO_BITS      = 16;
    localparam int CFG_ADDR_BITS = 4;
    localparam int CFG_DATA_BITS = 32;

    // event modes
    localparam logic [2:0] MODE_START      = 3'd0;
    localparam logic [2:0] MODE_ACK        = 3'd1;
    localparam logic [2:0] MODE_INVALIDATE = 3'd2;
    localparam logic [2:0] MODE_BACKOFF    = 3'd3;
    localparam logic [2:0] MODE_CLEAR      = 3'd4;

    // register word indexes
    localparam logic [1:0] REG_MIN_RTO   = 2'd0;
    localparam logic [1:0] REG_MAX_RTO   = 2'd1;
    localparam logic [1:0] REG_VAR_FLOOR = 2'd2;

    // reset values
    localparam logic [RTO_BITS-1:0] MIN_RTO_RESET   = 16'd1000;
    localparam logic [RTO_BITS-1:0] MAX_RTO_RESET   = 16'd60000;
    localparam logic [RTO_BITS-1:0] VAR_FLOOR_RESET = 16'd100;
    localparam logic [RTO_BITS-1:0] RTO_RESET       = 16'd1000;

    typedef struct packed {
        logic [RTO_BITS-1:0] min_rto;
        logic [RTO_BITS-1:0] max_rto;
        logic [RTO_BITS-1:0] variance_floor;
    } trto_cfg_t;

    typedef struct packed {
        logic [2:0]           mode;
        logic [SEQ_BITS-1:0]  seq_value;
        logic [SEQ_BITS-1:0]  seq_next;
        logic [TIME_BITS-1:0] now_ticks;
    } trto_item_t;

    typedef struct packed {
        logic [RTO_BITS-1:0] rto_value;
        logic [RTO_BITS-1:0] smoothed_rtt;
        logic [RTO_BITS-1:0] rtt_variance;
        logic                timing_active;
        logic                timing_blocked;
        logic                sample_taken;
    } trto_result_t;

    // true when sequence a is at or beyond b, modulo 2^32
    function automatic logic seq_reached(input logic [SEQ_BITS-1:0] a,
                                         input logic [SEQ_BITS-1:0] b);
        logic [SEQ_BITS-1:0] diff;
        diff = a - b;
        return !diff[SEQ_BITS-1];
    endfunction

endpackage

### design/trto_in_if.sv
// ----------------------------------------------------------------------------
// trto_in_if
// event channel into the estimator, valid/ready handshake
// ----------------------------------------------------------------------------
interface trto_in_if;
    import trto_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [2:0]           mode;
    logic [SEQ_BITS-1:0]  seq_value;
    logic [SEQ_BITS-1:0]  seq_next;
    logic [TIME_BITS-1:0] now_ticks;

    modport source (output valid, output mode, output seq_value, output seq_next,
                    output now_ticks, input ready);
    modport sink   (input valid, input mode, input seq_value, input seq_next,
                    input now_ticks, output ready);
endinterface

### design/trto_out_if.sv
// ----------------------------------------------------------------------------
// trto_out_if
// result channel out of the estimator, valid/ready handshake
// ----------------------------------------------------------------------------
interface trto_out_if;
    import trto_pkg::*;

    logic                valid;
    logic                ready;
    logic [RTO_BITS-1:0] rto_value;
    logic [RTO_BITS-1:0] smoothed_rtt;
    logic [RTO_BITS-1:0] rtt_variance;
    logic                timing_active;
    logic                timing_blocked;
    logic                sample_taken;

    modport source (output valid, output rto_value, output smoothed_rtt,
                    output rtt_variance, output timing_active, output timing_blocked,
                    output sample_taken, input ready);
    modport sink   (input valid, input rto_value, input smoothed_rtt,
                    input rtt_variance, input timing_active, input timing_blocked,
                    input sample_taken, output ready);
endinterface

### design/trto_cfg.sv
// ----------------------------------------------------------------------------
// trto_cfg
// apb register file: min_rto, max_rto, variance_floor
// ----------------------------------------------------------------------------
module trto_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [trto_pkg::CFG_ADDR_BITS-1:0] paddr,
    input  logic [trto_pkg::CFG_DATA_BITS-1:0] pwdata,
    output logic [trto_pkg::CFG_DATA_BITS-1:0] prdata,
    output trto_pkg::trto_cfg_t                cfg
);
    import trto_pkg::*;

    trto_cfg_t  cfg_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_rto        <= MIN_RTO_RESET;
            cfg_reg.max_rto        <= MAX_RTO_RESET;
            cfg_reg.variance_floor <= VAR_FLOOR_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_MIN_RTO:   cfg_reg.min_rto        <= pwdata[RTO_BITS-1:0];
                REG_MAX_RTO:   cfg_reg.max_rto        <= pwdata[RTO_BITS-1:0];
                REG_VAR_FLOOR: cfg_reg.variance_floor <= pwdata[RTO_BITS-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_MIN_RTO:   prdata = {{(CFG_DATA_BITS-RTO_BITS){1'b0}}, cfg_reg.min_rto};
            REG_MAX_RTO:   prdata = {{(CFG_DATA_BITS-RTO_BITS){1'b0}}, cfg_reg.max_rto};
            REG_VAR_FLOOR: prdata = {{(CFG_DATA_BITS-RTO_BITS){1'b0}},
                                     cfg_reg.variance_floor};
            default:       prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;
endmodule

### design/trto_est.sv
// ----------------------------------------------------------------------------
// trto_est
// connection state and combinational event update (jacobson smoothing, karn rule)
// ----------------------------------------------------------------------------
module trto_est (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fire,
    input  trto_pkg::trto_item_t  item,
    input  trto_pkg::trto_cfg_t   cfg,
    output trto_pkg::trto_result_t result
);
    import trto_pkg::*;

    logic [RTO_BITS-1:0]  srtt_reg, srtt_next;
    logic [RTO_BITS-1:0]  rttvar_reg, rttvar_next;
    logic [RTO_BITS-1:0]  rto_reg, rto_next;
    logic                 pending_reg, pending_next;
    logic                 blocked_reg, blocked_next;
    logic [TIME_BITS-1:0] start_time_reg, start_time_next;
    logic [SEQ_BITS-1:0]  timed_end_reg, timed_end_next;
    logic [SEQ_BITS-1:0]  block_until_reg, block_until_next;

    logic [TIME_BITS-1:0] elapsed;
    logic [TIME_BITS-1:0] elapsed_nz;
    logic [RTO_BITS-1:0]  sample;
    logic                 take;
    logic [RTO_BITS-1:0]  delta;
    logic [RTO_BITS+1:0]  var_sum;
    logic [RTO_BITS+2:0]  srtt_sum;
    logic [RTO_BITS-1:0]  srtt_new;
    logic [RTO_BITS-1:0]  var_new;
    logic [RTO_BITS+1:0]  var_term;
    logic [RTO_BITS+1:0]  var_term_fl;
    logic [RTO_BITS+2:0]  rto_sum;
    logic [RTO_BITS+2:0]  rto_lo;
    logic [RTO_BITS-1:0]  rto_new;
    logic [RTO_BITS:0]    rto_dbl;
    logic [RTO_BITS-1:0]  rto_boff;

    // sample path
    always_comb
    begin
        elapsed    = item.now_ticks - start_time_reg;
        elapsed_nz = (elapsed == '0) ? TIME_BITS'(1) : elapsed;
        sample     = (elapsed_nz > {{(TIME_BITS-RTO_BITS){1'b0}}, cfg.max_rto})
                     ? cfg.max_rto : elapsed_nz[RTO_BITS-1:0];
        take       = pending_reg && seq_reached(item.seq_value, timed_end_reg);

        delta    = (srtt_reg > sample) ? (srtt_reg - sample) : (sample - srtt_reg);
        var_sum  = (RTO_BITS+2)'(3) * {2'b00, rttvar_reg} + {2'b00, delta};
        srtt_sum = (RTO_BITS+3)'(7) * {3'b000, srtt_reg} + {3'b000, sample};

        if (srtt_reg == '0)
        begin
            srtt_new = sample;
            var_new  = sample >> 1;
        end
        else
        begin
            srtt_new = srtt_sum[RTO_BITS+2:3];
            var_new  = var_sum[RTO_BITS+1:2];
        end

        var_term    = {var_new, 2'b00};
        var_term_fl = (var_term < {2'b00, cfg.variance_floor})
                      ? {2'b00, cfg.variance_floor} : var_term;
        rto_sum     = {3'b000, srtt_new} + {1'b0, var_term_fl};
        rto_lo      = (rto_sum < {3'b000, cfg.min_rto}) ? {3'b000, cfg.min_rto} : rto_sum;
        rto_new     = (rto_lo > {3'b000, cfg.max_rto}) ? cfg.max_rto
                                                       : rto_lo[RTO_BITS-1:0];

        rto_dbl  = {rto_reg, 1'b0};
        rto_boff = (rto_dbl > {1'b0, cfg.max_rto}) ? cfg.max_rto : rto_dbl[RTO_BITS-1:0];
    end

    // next state per mode
    always_comb
    begin
        srtt_next        = srtt_reg;
        rttvar_next      = rttvar_reg;
        rto_next         = rto_reg;
        pending_next     = pending_reg;
        blocked_next     = blocked_reg;
        start_time_next  = start_time_reg;
        timed_end_next   = timed_end_reg;
        block_until_next = block_until_reg;
        result.sample_taken = 1'b0;

        case (item.mode)
            MODE_START:
            begin
                if (!pending_reg && !blocked_reg)
                begin
                    pending_next    = 1'b1;
                    start_time_next = item.now_ticks;
                    timed_end_next  = item.seq_value;
                end
            end
            MODE_ACK:
            begin
                if (take)
                begin
                    srtt_next    = srtt_new;
                    rttvar_next  = var_new;
                    rto_next     = rto_new;
                    pending_next = 1'b0;
                    result.sample_taken = 1'b1;
                end
                if (blocked_reg && seq_reached(item.seq_value, block_until_reg))
                    blocked_next = 1'b0;
            end
            MODE_INVALIDATE:
            begin
                pending_next     = 1'b0;
                blocked_next     = (item.seq_value != item.seq_next);
                block_until_next = item.seq_next;
            end
            MODE_BACKOFF:
                rto_next = rto_boff;
            MODE_CLEAR:
            begin
                pending_next = 1'b0;
                blocked_next = 1'b0;
            end
            default: ;
        endcase

        result.rto_value      = rto_next;
        result.smoothed_rtt   = srtt_next;
        result.rtt_variance   = rttvar_next;
        result.timing_active  = pending_next;
        result.timing_blocked = blocked_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            srtt_reg        <= '0;
            rttvar_reg      <= '0;
            rto_reg         <= RTO_RESET;
            pending_reg     <= 1'b0;
            blocked_reg     <= 1'b0;
            start_time_reg  <= '0;
            timed_end_reg   <= '0;
            block_until_reg <= '0;
        end
        else if (fire)
        begin
            srtt_reg        <= srtt_next;
            rttvar_reg      <= rttvar_next;
            rto_reg         <= rto_next;
            pending_reg     <= pending_next;
            blocked_reg     <= blocked_next;
            start_time_reg  <= start_time_next;
            timed_end_reg   <= timed_end_next;
            block_until_reg <= block_until_next;
        end
    end
endmodule

### design/tcp_rto_estimator_top.sv
// flow: an accepted event passes the event register, then the result register
// throughput: one event per cycle unless the output stalls; each state update is
//   combinational logic from the event register into the connection registers
// reset: rst_n is asynchronous, active low; clears both pipeline stages and
//   loads rto 1000, min_rto 1000, max_rto 60000, variance_floor 100
// ----------------------------------------------------------------------------
// tcp_rto_estimator_top
// per-connection retransmission timeout estimator with karn's rule
// ----------------------------------------------------------------------------
module tcp_rto_estimator_top (
    input  logic                               clk,
    input  logic                               rst_n,
    trto_in_if.sink                            in_ch,
    trto_out_if.source                         out_ch,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [trto_pkg::CFG_ADDR_BITS-1:0] paddr,
    input  logic [trto_pkg::CFG_DATA_BITS-1:0] pwdata,
    output logic [trto_pkg::CFG_DATA_BITS-1:0] prdata,
    output logic                               pready
);
    import trto_pkg::*;

    trto_cfg_t    cfg;
    trto_item_t   item_reg;
    logic         item_valid_reg;
    trto_result_t res_comb;
    trto_result_t res_reg;
    logic         res_valid_reg;

    logic out_open;   // result register can take a new value this cycle
    logic s1_fire;    // event register hands its event to the update logic
    logic in_fire;    // input transfer

    // register file, writes always complete in the access phase
    assign pready = 1'b1;

    trto_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // handshake: the result register decouples the sides, so a new event is
    // taken while an older result waits, if the event register is free
    assign out_open    = !res_valid_reg || out_ch.ready;
    assign s1_fire     = item_valid_reg && out_open;
    assign in_ch.ready = !item_valid_reg || out_open;
    assign in_fire     = in_ch.valid && in_ch.ready;

    // event register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (in_fire)
            item_valid_reg <= 1'b1;
        else if (s1_fire)
            item_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            item_reg.mode      <= in_ch.mode;
            item_reg.seq_value <= in_ch.seq_value;
            item_reg.seq_next  <= in_ch.seq_next;
            item_reg.now_ticks <= in_ch.now_ticks;
        end
    end

    // connection state and update logic; state advances only on s1_fire
    trto_est u_est (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (s1_fire),
        .item   (item_reg),
        .cfg    (cfg),
        .result (res_comb)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (s1_fire)
            res_valid_reg <= 1'b1;
        else if (out_ch.ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
            res_reg <= res_comb;
    end

    assign out_ch.valid          = res_valid_reg;
    assign out_ch.rto_value      = res_reg.rto_value;
    assign out_ch.smoothed_rtt   = res_reg.smoothed_rtt;
    assign out_ch.rtt_variance   = res_reg.rtt_variance;
    assign out_ch.timing_active  = res_reg.timing_active;
    assign out_ch.timing_blocked = res_reg.timing_blocked;
    assign out_ch.sample_taken   = res_reg.sample_taken;
endmodule

### design/trto_checker.sv
// ----------------------------------------------------------------------------
// trto_checker
// port-level checks of the estimator's transfer flow
// ----------------------------------------------------------------------------
module trto_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [trto_pkg::RTO_BITS-1:0] out_rto_value,
    input logic [trto_pkg::RTO_BITS-1:0] out_smoothed_rtt,
    input logic                          out_sample_taken
);
    import trto_pkg::*;

    logic [1:0] inflight_reg;
    logic       in_xfer;
    logic       out_xfer;

    assign in_xfer  = in_valid && in_ready;
    assign out_xfer = out_valid && out_ready;

    // events accepted but whose result transfer has not happened yet
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            inflight_reg <= '0;
        else if (in_xfer && !out_xfer)
            inflight_reg <= inflight_reg + 2'd1;
        else if (out_xfer && !in_xfer)
            inflight_reg <= inflight_reg - 2'd1;
    end

    // a stalled result holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_rto_value)
            && $stable(out_smoothed_rtt) && $stable(out_sample_taken))
        else $error("result changed while stalled");

    // two stages at most hold events
    a_inflight_max: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg != 2'd3)
        else $error("more events in flight than stages");

    // no result without an accepted event behind it
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> inflight_reg != 2'd0)
        else $error("result shown with no event in flight");

    // an empty result stage never holds off the input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled while result stage empty");
endmodule

bind tcp_rto_estimator_top trto_checker u_trto_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_ch.valid),
    .in_ready         (in_ch.ready),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_rto_value    (out_ch.rto_value),
    .out_smoothed_rtt (out_ch.smoothed_rtt),
    .out_sample_taken (out_ch.sample_taken)
);

### sim/tcp_rto_estimator_top_test.sv
// ----------------------------------------------------------------------------
// tcp_rto_estimator_top_test
// self-checking bench for the retransmission timeout estimator: a table of
// directed events, then randomized connection traffic under several register
// settings, results checked against hand-written values or an in-bench estimator
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tcp_rto_estimator_top_test;
    import trto_pkg::*;

    // modes the block ignores
    localparam logic [2:0] MODE_SPARE_LO  = 3'd5;
    localparam logic [2:0] MODE_SPARE_MID = 3'd6;
    localparam logic [2:0] MODE_SPARE_HI  = 3'd7;

    localparam int NUM_SETTINGS    = 6;
    localparam int ITEMS_PER_PHASE = 225;
    localparam int SHOWN_MISMATCH  = 10;

    // estimator state as the bench tracks it
    typedef struct packed {
        logic [RTO_BITS-1:0]  srtt;
        logic [RTO_BITS-1:0]  rttvar;
        logic [RTO_BITS-1:0]  rto;
        logic                 pending;
        logic                 blocked;
        logic [TIME_BITS-1:0] t_start;
        logic [SEQ_BITS-1:0]  end_seq;
        logic [SEQ_BITS-1:0]  block_seq;
    } conn_state_t;

    // one row of the directed table; typed rows carry a hand-written result
    typedef struct {
        trto_item_t   ev;
        bit           typed;
        trto_result_t want;
    } probe_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [CFG_ADDR_BITS-1:0] paddr;
    logic [CFG_DATA_BITS-1:0] pwdata;
    logic [CFG_DATA_BITS-1:0] prdata;
    logic                     pready;

    trto_in_if  in_ch ();
    trto_out_if out_ch ();

    tcp_rto_estimator_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // 4 ns period
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // bench copy of the registers and the connection state
    trto_cfg_t    cfg;
    conn_state_t  conn;

    // results still owed by the block, oldest first
    trto_result_t estimates_due [$];
    probe_row_t   probe_table [$];

    // idling control: when steady, that side never waits
    bit source_steady;
    bit sink_steady;

    int mismatches;
    int results_checked;
    int samples_seen;
    int mode_seen [8];

    // ------------------------------------------------------------------------
    // estimator: applies one event to the bench state and returns the result
    // ------------------------------------------------------------------------
    function automatic trto_result_t estimate_step(input trto_item_t ev);
        logic [SEQ_BITS-1:0]  seq_gap;
        logic [TIME_BITS-1:0] elapsed;
        logic [31:0]          sample;
        logic [31:0]          delta;
        logic [31:0]          scratch;
        logic [31:0]          var_term;
        logic [31:0]          next_rto;
        logic                 sampled;
        trto_result_t         res;

        sampled = 1'b0;
        case (ev.mode)
            MODE_START:
            begin
                // karn: no new timing while a sample is out or blocked
                if (!conn.pending && !conn.blocked)
                begin
                    conn.pending = 1'b1;
                    conn.t_start = ev.now_ticks;
                    conn.end_seq = ev.seq_value;
                end
            end
            MODE_ACK:
            begin
                seq_gap = ev.seq_value - conn.end_seq;
                if (conn.pending && !seq_gap[SEQ_BITS-1])
                begin
                    elapsed = ev.now_ticks - conn.t_start;
                    if (elapsed == '0)
                        elapsed = TIME_BITS'(1);
                    if (elapsed > cfg.max_rto)
                        sample = 32'(cfg.max_rto);
                    else
                        sample = elapsed[31:0];
                    if (conn.srtt == '0)
                    begin
                        // first sample seeds both averages
                        conn.srtt = sample[15:0];
                        scratch = sample >> 1;
                        conn.rttvar = scratch[15:0];
                    end
                    else
                    begin
                        if (conn.srtt > sample)
                            delta = conn.srtt - sample;
                        else
                            delta = sample - conn.srtt;
                        scratch = (conn.rttvar * 3 + delta) >> 2;
                        conn.rttvar = scratch[15:0];
                        scratch = (conn.srtt * 7 + sample) >> 3;
                        conn.srtt = scratch[15:0];
                    end
                    var_term = conn.rttvar * 4;
                    if (var_term < cfg.variance_floor)
                        var_term = 32'(cfg.variance_floor);
                    next_rto = conn.srtt + var_term;
                    // floor first, ceiling last: the ceiling wins on overlap
                    if (next_rto < cfg.min_rto)
                        next_rto = 32'(cfg.min_rto);
                    if (next_rto > cfg.max_rto)
                        next_rto = 32'(cfg.max_rto);
                    conn.rto = next_rto[15:0];
                    conn.pending = 1'b0;
                    sampled = 1'b1;
                end
                seq_gap = ev.seq_value - conn.block_seq;
                if (conn.blocked && !seq_gap[SEQ_BITS-1])
                    conn.blocked = 1'b0;
            end
            MODE_INVALIDATE:
            begin
                conn.pending   = 1'b0;
                conn.blocked   = (ev.seq_value != ev.seq_next);
                conn.block_seq = ev.seq_next;
            end
            MODE_BACKOFF:
            begin
                scratch = conn.rto * 2;
                if (scratch > cfg.max_rto)
                    scratch = 32'(cfg.max_rto);
                conn.rto = scratch[15:0];
            end
            MODE_CLEAR:
            begin
                conn.pending = 1'b0;
                conn.blocked = 1'b0;
            end
            default:
            begin
            end
        endcase
        res.rto_value      = conn.rto;
        res.smoothed_rtt   = conn.srtt;
        res.rtt_variance   = conn.rttvar;
        res.timing_active  = conn.pending;
        res.timing_blocked = conn.blocked;
        res.sample_taken   = sampled;
        return res;
    endfunction

    function automatic void add_probe(input logic [2:0] mode, input logic [31:0] seq_value,
                                      input logic [31:0] seq_next, input logic [47:0] now,
                                      input bit typed, input trto_result_t want);
        probe_row_t row;

        row.ev.mode      = mode;
        row.ev.seq_value = seq_value;
        row.ev.seq_next  = seq_next;
        row.ev.now_ticks = now;
        row.typed        = typed;
        row.want         = want;
        probe_table.push_back(row);
    endfunction

    task automatic flag_mismatch(input string field, input logic [15:0] want,
                                 input logic [15:0] got);
        mismatches++;
        if (mismatches <= SHOWN_MISMATCH)
            $display("[%0t] %s mismatch: expected %0d, got %0d", $time, field, want, got);
    endtask

    // one event transfer; the estimate is taken at the accepting edge
    task automatic send_event(input trto_item_t ev, input bit typed, input trto_result_t want);
        int           gap;
        trto_result_t predicted;

        gap = source_steady ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.mode      <= ev.mode;
        in_ch.seq_value <= ev.seq_value;
        in_ch.seq_next  <= ev.seq_next;
        in_ch.now_ticks <= ev.now_ticks;
        do
            @(posedge clk);
        while (!in_ch.ready);
        predicted = estimate_step(ev);
        estimates_due.push_back(typed ? want : predicted);
        mode_seen[ev.mode]++;
        if (predicted.sample_taken)
            samples_seen++;
    endtask

    // setup cycle then access cycle; psel stays up for back-to-back writes
    task automatic write_reg(input logic [1:0] index, input logic [15:0] value);
        logic [15:0] upper;

        upper = 16'($urandom);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= {upper, value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (index)
            REG_MIN_RTO:   cfg.min_rto = value;
            REG_MAX_RTO:   cfg.max_rto = value;
            REG_VAR_FLOOR: cfg.variance_floor = value;
            default:       ;
        endcase
    endtask

    // sender holds off until every owed result has come back
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (estimates_due.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // result side: random stalls, field-by-field check on every transfer
    // ------------------------------------------------------------------------
    initial
    begin : result_sink
        int           stall;
        trto_result_t got;
        trto_result_t want;

        out_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = sink_steady ? 0 : $urandom_range(0, 5);
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_ch.valid);
            got.rto_value      = out_ch.rto_value;
            got.smoothed_rtt   = out_ch.smoothed_rtt;
            got.rtt_variance   = out_ch.rtt_variance;
            got.timing_active  = out_ch.timing_active;
            got.timing_blocked = out_ch.timing_blocked;
            got.sample_taken   = out_ch.sample_taken;
            if (estimates_due.size() == 0)
            begin
                flag_mismatch("unrequested result rto_value", 16'd0, got.rto_value);
            end
            else
            begin
                want = estimates_due.pop_front();
                results_checked++;
                if (got.rto_value !== want.rto_value)
                    flag_mismatch("rto_value", want.rto_value, got.rto_value);
                if (got.smoothed_rtt !== want.smoothed_rtt)
                    flag_mismatch("smoothed_rtt", want.smoothed_rtt, got.smoothed_rtt);
                if (got.rtt_variance !== want.rtt_variance)
                    flag_mismatch("rtt_variance", want.rtt_variance, got.rtt_variance);
                if (got.timing_active !== want.timing_active)
                    flag_mismatch("timing_active", 16'(want.timing_active),
                                  16'(got.timing_active));
                if (got.timing_blocked !== want.timing_blocked)
                    flag_mismatch("timing_blocked", 16'(want.timing_blocked),
                                  16'(got.timing_blocked));
                if (got.sample_taken !== want.sample_taken)
                    flag_mismatch("sample_taken", 16'(want.sample_taken),
                                  16'(got.sample_taken));
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        trto_cfg_t            settings [NUM_SETTINGS];
        trto_item_t           ev;
        logic [SEQ_BITS-1:0]  snd_una;
        logic [SEQ_BITS-1:0]  snd_nxt;
        logic [SEQ_BITS-1:0]  target;
        logic [SEQ_BITS-1:0]  seq_gap;
        logic [TIME_BITS-1:0] clock_now;
        logic [TIME_BITS-1:0] elapsed_draw;
        logic [31:0]          span;
        int                   counted;
        int                   pick;
        bit                   paused;

        // every input known before the first edge
        in_ch.valid     = 1'b0;
        in_ch.mode      = MODE_START;
        in_ch.seq_value = '0;
        in_ch.seq_next  = '0;
        in_ch.now_ticks = '0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        source_steady   = 1'b0;
        sink_steady     = 1'b0;
        paused          = 1'b0;

        cfg.min_rto        = MIN_RTO_RESET;
        cfg.max_rto        = MAX_RTO_RESET;
        cfg.variance_floor = VAR_FLOOR_RESET;
        conn               = '0;
        conn.rto           = RTO_RESET;

        // settings walked by the random part: reset values, wide open,
        // crossed clamps, a narrow band, a zero ceiling, then a random pick
        settings[0] = {MIN_RTO_RESET, MAX_RTO_RESET, VAR_FLOOR_RESET};
        settings[1] = {16'd1, 16'd65535, 16'd0};
        settings[2] = {16'd65535, 16'd1, 16'd65535};
        settings[3] = {16'd300, 16'd5000, 16'd1};
        settings[4] = {16'd50, 16'd0, 16'd20};
        settings[5].min_rto        = 16'($urandom_range(1, 2000));
        settings[5].max_rto        = 16'($urandom_range(1000, 65535));
        settings[5].variance_floor = 16'($urandom_range(0, 500));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed table, under reset register values
        // unused modes report the untouched reset state
        add_probe(MODE_SPARE_HI, '1, '1, '1, 1'b1, {16'd1000, 16'd0, 16'd0, 3'b000});
        add_probe(MODE_SPARE_LO, '0, '0, '0, 1'b1, {16'd1000, 16'd0, 16'd0, 3'b000});
        // backoff doubles the reset timeout
        add_probe(MODE_BACKOFF, '0, '0, '0, 1'b1, {16'd2000, 16'd0, 16'd0, 3'b000});
        // acknowledge with nothing timed
        add_probe(MODE_ACK, '0, '0, '0, 1'b1, {16'd2000, 16'd0, 16'd0, 3'b000});
        add_probe(MODE_START, 32'd100, '0, 48'd1000, 1'b1, {16'd2000, 16'd0, 16'd0, 3'b100});
        // start while a sample is out is dropped
        add_probe(MODE_START, 32'd500, '0, 48'd5000, 1'b1, {16'd2000, 16'd0, 16'd0, 3'b100});
        // ack short of the timed end
        add_probe(MODE_ACK, 32'd99, '0, 48'd1500, 1'b1, {16'd2000, 16'd0, 16'd0, 3'b100});
        // zero elapsed time counts as one tick, timeout raised to the floor clamp
        add_probe(MODE_ACK, 32'd100, '0, 48'd1000, 1'b1, {16'd1000, 16'd1, 16'd0, 3'b001});
        // sequence and time both wrap between start and ack
        add_probe(MODE_START, 32'hFFFF_FFF0, '0, 48'hFFFF_FFFF_FFF0, 1'b0, '0);
        add_probe(MODE_ACK, 32'h0000_0010, '0, 48'h0000_0000_0010, 1'b0, '0);
        // half a sequence space ahead is behind, one less is ahead
        add_probe(MODE_START, '0, '0, '0, 1'b0, '0);
        add_probe(MODE_ACK, 32'h8000_0000, '0, 48'd50, 1'b0, '0);
        // huge elapsed time clamps the sample
        add_probe(MODE_ACK, 32'h7FFF_FFFF, '0, '1, 1'b0, '0);
        // backoff saturates at the ceiling
        add_probe(MODE_BACKOFF, '0, '0, '0, 1'b0, '0);
        add_probe(MODE_BACKOFF, '1, '1, '1, 1'b0, '0);
        // invalidate with nothing in flight does not block
        add_probe(MODE_INVALIDATE, 32'd5, 32'd5, '0, 1'b0, '0);
        // karn blocking: timing dropped, new start refused until acked past
        add_probe(MODE_START, 32'd40, '0, 48'd100, 1'b0, '0);
        add_probe(MODE_INVALIDATE, 32'd10, 32'd50, '0, 1'b0, '0);
        add_probe(MODE_START, 32'd60, '0, 48'd200, 1'b0, '0);
        add_probe(MODE_ACK, 32'd49, '0, 48'd250, 1'b0, '0);
        add_probe(MODE_ACK, 32'd50, '0, 48'd300, 1'b0, '0);
        // clear ends timing and blocking
        add_probe(MODE_START, 32'd70, '0, 48'd400, 1'b0, '0);
        add_probe(MODE_CLEAR, '0, '0, '0, 1'b0, '0);
        add_probe(MODE_INVALIDATE, '0, '1, '0, 1'b0, '0);
        add_probe(MODE_CLEAR, '1, '1, '1, 1'b0, '0);
        add_probe(MODE_SPARE_MID, 32'h5A5A_A5A5, 32'hA5A5_5A5A, 48'h5555_AAAA_5555, 1'b0, '0);

        foreach (probe_table[k])
            send_event(probe_table[k].ev, probe_table[k].typed, probe_table[k].want);
        drain_results();

        // connection traffic starts close to both wrap points
        snd_una   = 32'hFFFF_C000;
        snd_nxt   = snd_una;
        clock_now = 48'hFFFF_FF00_0000;

        for (int phase = 0; phase < NUM_SETTINGS; phase++)
        begin
            // registers change only with nothing in flight
            if (phase != 0)
            begin
                write_reg(REG_MAX_RTO, settings[phase].max_rto);
                write_reg(REG_MIN_RTO, settings[phase].min_rto);
                write_reg(REG_VAR_FLOOR, settings[phase].variance_floor);
                psel    <= 1'b0;
                penable <= 1'b0;
                pwrite  <= 1'b0;
            end
            span    = 32'(cfg.max_rto);
            counted = 0;
            while (counted < ITEMS_PER_PHASE)
            begin
                // stretches without any idling on either side
                if ($urandom_range(0, 29) == 0)
                    source_steady = !source_steady;
                if ($urandom_range(0, 29) == 0)
                    sink_steady = !sink_steady;
                // once mid-run, the sender waits for every result to return
                if (phase == 3 && counted == ITEMS_PER_PHASE / 2 && !paused)
                begin
                    paused = 1'b1;
                    drain_results();
                end

                clock_now    = clock_now + $urandom_range(0, 20);
                ev.seq_next  = $urandom;
                ev.now_ticks = clock_now;
                pick = $urandom_range(0, 99);
                if (pick < 7)
                begin
                    // noise: any mode, any field
                    ev.mode         = 3'($urandom_range(0, 7));
                    ev.seq_value    = $urandom;
                    elapsed_draw    = TIME_BITS'({$urandom, $urandom});
                    ev.now_ticks    = elapsed_draw;
                end
                else if (pick < 15)
                begin
                    // retransmission: drop the sample, mostly block up to snd_nxt
                    ev.mode      = MODE_INVALIDATE;
                    ev.seq_value = snd_una;
                    ev.seq_next  = ($urandom_range(0, 4) == 0) ? snd_una : snd_nxt;
                end
                else if (pick < 22)
                begin
                    ev.mode      = MODE_BACKOFF;
                    ev.seq_value = $urandom;
                end
                else if (pick < 25)
                begin
                    ev.mode      = MODE_CLEAR;
                    ev.seq_value = $urandom;
                end
                else if (!conn.pending && !conn.blocked && $urandom_range(0, 4) != 0)
                begin
                    // new segment goes out and is timed
                    snd_nxt      = snd_nxt + $urandom_range(1, 1460);
                    ev.mode      = MODE_START;
                    ev.seq_value = snd_nxt;
                end
                else
                begin
                    // round trip mostly within the clamp, now and then none or huge
                    case ($urandom_range(0, 19))
                        0:       elapsed_draw = '0;
                        1:       elapsed_draw = TIME_BITS'({$urandom, $urandom});
                        default: elapsed_draw = TIME_BITS'($urandom_range(1,
                                                           span + span / 4 + 1));
                    endcase
                    clock_now = clock_now + elapsed_draw;
                    if (conn.pending)
                        target = conn.end_seq;
                    else if (conn.blocked)
                        target = conn.block_seq;
                    else
                        target = snd_nxt;
                    case ($urandom_range(0, 9))
                        0, 1:    ev.seq_value = target - $urandom_range(1, 2000);
                        8, 9:    ev.seq_value = target + $urandom_range(1, 3000);
                        default: ev.seq_value = target;
                    endcase
                    ev.mode      = MODE_ACK;
                    ev.now_ticks = clock_now;
                    seq_gap = ev.seq_value - snd_una;
                    if (!seq_gap[SEQ_BITS-1])
                        snd_una = ev.seq_value;
                    seq_gap = ev.seq_value - snd_nxt;
                    if (!seq_gap[SEQ_BITS-1])
                        snd_nxt = ev.seq_value;
                end

                // ignored events do not count toward the phase
                if (!(ev.mode > MODE_CLEAR ||
                      (ev.mode == MODE_START && (conn.pending || conn.blocked))))
                    counted++;
                send_event(ev, 1'b0, '0);
            end
            drain_results();
        end

        // tail: wait on to catch any stray transfer
        repeat (8) @(posedge clk);

        $display("covered: start %0d, ack %0d, invalidate %0d, backoff %0d, clear %0d, unused %0d",
                 mode_seen[MODE_START], mode_seen[MODE_ACK], mode_seen[MODE_INVALIDATE],
                 mode_seen[MODE_BACKOFF], mode_seen[MODE_CLEAR],
                 mode_seen[MODE_SPARE_LO] + mode_seen[MODE_SPARE_MID] + mode_seen[MODE_SPARE_HI]);
        $display("%0d rtt samples over %0d register settings, %0d results checked, %0d mismatches",
                 samples_seen, NUM_SETTINGS, results_checked, mismatches);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // hard stop far beyond the slowest legal run
    initial
    begin : watchdog
        #2_000_000;
        $display("timeout with %0d results outstanding", estimates_due.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
